@@ src/stt_pkg.sv @@
// Types and constants shared by the source text tokenizer.
`default_nettype none
package stt_pkg;

   // Result fields are fixed at 24 bits for positions.
   localparam int PosOutW = 24;
   localparam int PrefixBytes = 6;
   localparam int KwCount = 11;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_marker;
   } stt_req_type;

   typedef struct packed {
      logic [2:0]         token_kind;
      logic [3:0]         keyword_index;
      logic [PosOutW-1:0] start_offset;
      logic [7:0]         text_length;
      logic [PosOutW-1:0] line_number;
      logic [7:0]         first_text_byte;
      logic [7:0]         second_text_byte;
      logic               last_of_run;
   } stt_rsp_type;

   typedef enum logic [5:0] {
      MODE_IDLE    = 6'b000001,
      MODE_IDENT   = 6'b000010,
      MODE_INT     = 6'b000100,
      MODE_STRING  = 6'b001000,
      MODE_COMMENT = 6'b010000,
      MODE_PEND    = 6'b100000
   } scan_mode_type;

   // Token kinds
   localparam logic [2:0] KIND_EOF     = 3'd0;
   localparam logic [2:0] KIND_IDENT   = 3'd1;
   localparam logic [2:0] KIND_INT     = 3'd2;
   localparam logic [2:0] KIND_STRING  = 3'd3;
   localparam logic [2:0] KIND_KEYWORD = 3'd4;
   localparam logic [2:0] KIND_OP      = 3'd5;
   localparam logic [2:0] KIND_PUNCT   = 3'd6;

   // Character codes
   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_PCT   = 8'h25;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_STAR  = 8'h2A;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_BAR   = 8'h7C;
   localparam logic [7:0] CH_UNDER = 8'h5F;

   // Keywords, right-aligned in a 48-bit prefix; index is the keyword number.
   localparam logic [47:0] KW_TEXT [KwCount] = '{
      48'h0000_0000_666E,   // fn
      48'h0000_006C_6574,   // let
      48'h0000_0076_6172,   // var
      48'h0000_0000_6966,   // if
      48'h0000_656C_7365,   // else
      48'h0077_6869_6C65,   // while
      48'h0000_0066_6F72,   // for
      48'h7265_7475_726E,   // return
      48'h0000_7472_7565,   // true
      48'h0066_616C_7365,   // false
      48'h0000_0000_696E    // in
   };
   localparam logic [7:0] KW_LEN [KwCount] = '{
      8'd2, 8'd3, 8'd3, 8'd2, 8'd4, 8'd5, 8'd3, 8'd6, 8'd4, 8'd5, 8'd2
   };

endpackage
`default_nettype wire

@@ src/source_text_tokenizer_unit.sv @@
// Streaming lexical tokenizer: source bytes in, token records out.
//
//  channel   dir  payload        accepted when
//  req_*     in   stt_req_type   req_valid && req_ready
//  rsp_*     out  stt_rsp_type   rsp_valid && rsp_ready
//
// Each accepted byte is scanned in the cycle it is accepted and its records
// (zero, one or two) land in a three-entry result queue the next cycle.
// One byte per cycle while req_ready is high; a byte that makes two records
// sends them one after the other through the single result port.
// req_ready is high while the queue holds at most one record, so a stalled
// consumer backs up the input once two records are waiting.
// Synchronous active-high reset: scan state to idle, offset 0, line 1, queue empty.
`default_nettype none
module source_text_tokenizer_unit #(
   parameter int MAX_TEXT      = 255,
   parameter int POSITION_BITS = 24
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  stt_pkg::stt_req_type req_payload,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output stt_pkg::stt_rsp_type rsp_payload
);
   import stt_pkg::*;

   localparam int PB = POSITION_BITS;
   localparam logic [PB-1:0] PosOne = PB'(1);

   // ---------------- scan state ----------------
   scan_mode_type mode_ff, mode_in;
   logic [PB-1:0] offset_ff, offset_in;
   logic [PB-1:0] line_ff, line_in;
   logic [PB-1:0] tok_start_ff, tok_start_in;
   logic [PB-1:0] tok_line_ff, tok_line_in;
   logic [7:0]    count_ff, count_in;
   logic [47:0]   prefix_ff, prefix_in;
   logic [7:0]    pend_ff, pend_in;

   // ---------------- result queue ----------------
   stt_rsp_type   q_ff [3];
   stt_rsp_type   q_in [3];
   stt_rsp_type   shifted [3];
   logic [1:0]    q_cnt_ff, q_cnt_in, base;

   logic          accept, pop, eos;
   logic [7:0]    c;

   stt_rsp_type   close_rec, begin_rec, eof_rec, op2_rec, out0, out1;
   logic          close_hit, begin_hit, rec_a_hit, rec_b_hit;
   stt_rsp_type   rec_b;
   logic [1:0]    n_rec;

   scan_mode_type begin_mode;
   logic [PB-1:0] begin_start;
   logic [7:0]    begin_count, begin_pend;
   logic [47:0]   begin_prefix;

   logic          kw_hit;
   logic [3:0]    kw_idx;

   function automatic logic is_alpha(input logic [7:0] ch);
      return (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A) || ch == CH_UNDER;
   endfunction

   function automatic logic is_digit(input logic [7:0] ch);
      return ch >= 8'h30 && ch <= 8'h39;
   endfunction

   function automatic logic [PB-1:0] pos_inc(input logic [PB-1:0] v);
      return (v == '1) ? v : v + PosOne;
   endfunction

   function automatic logic [7:0] count_inc(input logic [7:0] v);
      return (v < 8'(MAX_TEXT)) ? v + 8'd1 : v;
   endfunction

   function automatic stt_rsp_type make_rec(
      input logic [2:0]    kind,
      input logic [3:0]    kw,
      input logic [PB-1:0] start,
      input logic [7:0]    len,
      input logic [PB-1:0] line,
      input logic [7:0]    b1,
      input logic [7:0]    b2
   );
      stt_rsp_type r;
      r.token_kind       = kind;
      r.keyword_index    = kw;
      r.start_offset     = PosOutW'(start);
      r.text_length      = len;
      r.line_number      = PosOutW'(line);
      r.first_text_byte  = b1;
      r.second_text_byte = b2;
      r.last_of_run      = 1'b0;
      return r;
   endfunction

   assign c      = req_payload.in_byte;
   assign eos    = req_payload.end_marker || (c == CH_NUL);
   assign accept = req_valid && req_ready;
   assign pop    = rsp_valid && rsp_ready;

   // Keyword match on the open identifier; lengths above six never match.
   always_comb begin
      kw_hit = 1'b0;
      kw_idx = 4'd0;
      for (int i = 0; i < KwCount; i++) begin
         if (count_ff == KW_LEN[i] && prefix_ff == KW_TEXT[i]) begin
            kw_hit = 1'b1;
            kw_idx = 4'(i);
         end
      end
   end

   // Record that closes the open token, if any.
   always_comb begin
      close_hit = 1'b1;
      unique case (mode_ff)
         MODE_IDENT: begin
            close_rec = kw_hit
               ? make_rec(KIND_KEYWORD, kw_idx, tok_start_ff, count_ff, tok_line_ff, 8'd0, 8'd0)
               : make_rec(KIND_IDENT, 4'd0, tok_start_ff, count_ff, tok_line_ff, 8'd0, 8'd0);
         end
         MODE_INT:
            close_rec = make_rec(KIND_INT, 4'd0, tok_start_ff, count_ff, tok_line_ff,
                                 8'd0, 8'd0);
         MODE_STRING:
            close_rec = make_rec(KIND_STRING, 4'd0, tok_start_ff, count_ff, tok_line_ff,
                                 8'd0, 8'd0);
         MODE_PEND:
            close_rec = make_rec(KIND_OP, 4'd0, tok_start_ff, 8'd1, tok_line_ff,
                                 pend_ff, 8'd0);
         default: begin
            close_hit = 1'b0;
            close_rec = make_rec(KIND_EOF, 4'd0, tok_start_ff, 8'd0, tok_line_ff,
                                 8'd0, 8'd0);
         end
      endcase
   end

   // Token that this byte opens.
   always_comb begin
      begin_start  = offset_ff;
      begin_count  = 8'd1;
      begin_prefix = '0;
      begin_pend   = 8'd0;
      begin_hit    = 1'b0;
      begin_mode   = MODE_IDLE;
      begin_rec    = make_rec(KIND_PUNCT, 4'd0, offset_ff, 8'd1, line_ff, c, 8'd0);
      priority if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR) begin
         begin_mode = MODE_IDLE;
      end else if (is_alpha(c)) begin
         begin_mode   = MODE_IDENT;
         begin_prefix = {40'd0, c};
      end else if (is_digit(c)) begin
         begin_mode = MODE_INT;
      end else if (c == CH_QUOTE) begin
         begin_mode  = MODE_STRING;
         begin_start = pos_inc(offset_ff);
         begin_count = 8'd0;
      end else if (c == CH_SLASH || c == CH_EQ || c == CH_BANG || c == CH_LT ||
                   c == CH_GT || c == CH_AMP || c == CH_BAR) begin
         begin_mode = MODE_PEND;
         begin_pend = c;
      end else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_PCT) begin
         begin_hit = 1'b1;
         begin_rec = make_rec(KIND_OP, 4'd0, offset_ff, 8'd1, line_ff, c, 8'd0);
      end else begin
         begin_hit = 1'b1;   // any other byte, including non-ASCII, is punctuation
      end
   end

   assign eof_rec = make_rec(KIND_EOF, 4'd0, offset_ff, 8'd0, line_ff, 8'd0, 8'd0);
   assign op2_rec = make_rec(KIND_OP, 4'd0, tok_start_ff, 8'd2, tok_line_ff, pend_ff, CH_EQ);

   // Per-byte scan step.
   always_comb begin
      logic restart;
      restart      = 1'b0;
      mode_in      = mode_ff;
      offset_in    = offset_ff;
      line_in      = line_ff;
      tok_start_in = tok_start_ff;
      tok_line_in  = tok_line_ff;
      count_in     = count_ff;
      prefix_in    = prefix_ff;
      pend_in      = pend_ff;
      rec_a_hit    = 1'b0;
      rec_b_hit    = 1'b0;
      rec_b        = begin_rec;
      if (accept) begin
         if (eos) begin
            // close the open token, report end of file, back to reset values
            rec_a_hit    = close_hit;
            rec_b        = eof_rec;
            rec_b_hit    = 1'b1;
            mode_in      = MODE_IDLE;
            offset_in    = '0;
            line_in      = PosOne;
            tok_start_in = '0;
            tok_line_in  = PosOne;
            count_in     = 8'd0;
            prefix_in    = '0;
            pend_in      = 8'd0;
         end else begin
            unique case (mode_ff)
               MODE_IDENT: begin
                  if (is_alpha(c) || is_digit(c)) begin
                     if (count_ff < 8'(PrefixBytes)) prefix_in = {prefix_ff[39:0], c};
                     count_in = count_inc(count_ff);
                  end else begin
                     restart = 1'b1;
                  end
               end
               MODE_INT: begin
                  if (is_digit(c)) count_in = count_inc(count_ff);
                  else restart = 1'b1;
               end
               MODE_STRING: begin
                  if (c == CH_QUOTE) begin
                     rec_a_hit = 1'b1;
                     mode_in   = MODE_IDLE;
                  end else begin
                     count_in = count_inc(count_ff);
                  end
               end
               MODE_COMMENT: begin
                  if (c == CH_LF) mode_in = MODE_IDLE;
               end
               MODE_PEND: begin
                  priority if (pend_ff == CH_SLASH && c == CH_SLASH) begin
                     mode_in = MODE_COMMENT;
                  end else if (pend_ff != CH_SLASH && c == CH_EQ) begin
                     rec_b     = op2_rec;
                     rec_b_hit = 1'b1;
                     mode_in   = MODE_IDLE;
                  end else begin
                     restart = 1'b1;
                  end
               end
               default: restart = 1'b1;   // idle between tokens
            endcase
            if (restart) begin
               rec_a_hit    = close_hit;
               rec_b_hit    = begin_hit;
               mode_in      = begin_mode;
               tok_start_in = begin_start;
               tok_line_in  = line_ff;
               count_in     = begin_count;
               prefix_in    = begin_prefix;
               pend_in      = begin_pend;
            end
            if (c == CH_LF) line_in = pos_inc(line_ff);
            offset_in = pos_inc(offset_ff);
         end
      end
   end

   // Pack the records of this byte in order; the last one carries last_of_run.
   always_comb begin
      out0 = rec_a_hit ? close_rec : rec_b;
      out0.last_of_run = !(rec_a_hit && rec_b_hit);
      out1 = rec_b;
      out1.last_of_run = 1'b1;
      n_rec = 2'(rec_a_hit) + 2'(rec_b_hit);
   end

   // Result queue: head at entry 0, pop shifts down, pushes append.
   always_comb begin
      base = q_cnt_ff - 2'(pop);
      shifted[0] = pop ? q_ff[1] : q_ff[0];
      shifted[1] = pop ? q_ff[2] : q_ff[1];
      shifted[2] = q_ff[2];
      for (int i = 0; i < 3; i++) begin
         q_in[i] = shifted[i];
         if (n_rec != 2'd0 && 2'(i) == base) q_in[i] = out0;
         if (n_rec == 2'd2 && 2'(i) == base + 2'd1) q_in[i] = out1;
      end
      q_cnt_in = base + n_rec;
   end

   assign req_ready   = (q_cnt_ff <= 2'd1);
   assign rsp_valid   = (q_cnt_ff != 2'd0);
   assign rsp_payload = q_ff[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_IDLE;
         offset_ff    <= '0;
         line_ff      <= PosOne;
         tok_start_ff <= '0;
         tok_line_ff  <= PosOne;
         count_ff     <= 8'd0;
         prefix_ff    <= '0;
         pend_ff      <= 8'd0;
         q_cnt_ff     <= 2'd0;
      end else begin
         mode_ff      <= mode_in;
         offset_ff    <= offset_in;
         line_ff      <= line_in;
         tok_start_ff <= tok_start_in;
         tok_line_ff  <= tok_line_in;
         count_ff     <= count_in;
         prefix_ff    <= prefix_in;
         pend_ff      <= pend_in;
         q_cnt_ff     <= q_cnt_in;
      end
   end

   // Queue payload needs no reset.
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Testbench for source_text_tokenizer_unit: token records checked against a scan predictor.
`timescale 1ns / 100ps
module tb_top;
   import stt_pkg::*;

   localparam int          ITEM_TARGET = 1850;     // source bytes queued at least
   localparam int          CYCLE_LIMIT = 1_000_000;
   localparam int          TAIL_CYCLES = 10;       // quiet cycles after the last record
   localparam logic [23:0] POS_TOP     = 24'hFF_FFFF;
   localparam logic [7:0]  TEXT_CAP    = 8'd255;

   // character class bounds
   localparam logic [7:0] CH_D0 = 8'h30, CH_D9 = 8'h39;
   localparam logic [7:0] CH_LA = 8'h61, CH_LZ = 8'h7A;
   localparam logic [7:0] CH_UA = 8'h41, CH_UZ = 8'h5A;

   localparam string WORD_CHARS  =
      "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
   localparam string OP_CHARS    = "+-*%/=!<>&|";
   localparam string PUNCT_CHARS = "(){}[];,.:#@$^~?'\\";

   typedef struct {
      stt_req_type req;
      int          gap;          // idle cycles after this request is taken
      bit          drain_first;  // hold this request until no record is owed
   } byte_slot_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   stt_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   stt_rsp_type rsp_payload;

   source_text_tokenizer_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Scan predictor: a private copy of the lexer state, advanced once per
   // accepted request. Records it produces go straight to token_queue.
   // ---------------------------------------------------------------------
   scan_mode_type lex_mode;
   logic [23:0]   lex_offset, lex_line;   // position of the next byte
   logic [23:0]   tok_start, tok_line;    // where the open token began
   logic [7:0]    tok_len;                // text bytes of the open token
   logic [47:0]   word_head;              // first six identifier bytes
   logic [7:0]    held_op;                // operator byte waiting on its successor
   int            step_count;             // records made by the current request

   stt_rsp_type   token_queue[$];         // records owed by the block, oldest first
   int            fail_count = 0;

   function automatic logic [23:0] sat_inc(input logic [23:0] v);
      return (v == POS_TOP) ? v : v + 24'd1;
   endfunction

   function automatic bit is_letter(input logic [7:0] c);
      return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ) || c == CH_UNDER;
   endfunction

   function automatic bit is_digit_ch(input logic [7:0] c);
      return c >= CH_D0 && c <= CH_D9;
   endfunction

   function automatic void reset_lexer();
      lex_mode   = MODE_IDLE;
      lex_offset = '0;
      lex_line   = 24'd1;
      tok_start  = '0;
      tok_line   = 24'd1;
      tok_len    = '0;
      word_head  = '0;
      held_op    = '0;
   endfunction

   function automatic void emit(input logic [2:0] kind, input logic [3:0] kw,
                                input logic [23:0] start, input logic [7:0] len,
                                input logic [23:0] ln, input logic [7:0] b1,
                                input logic [7:0] b2);
      stt_rsp_type rec;
      if (step_count >= 2) return;
      rec.token_kind       = kind;
      rec.keyword_index    = kw;
      rec.start_offset     = start;
      rec.text_length      = len;
      rec.line_number      = ln;
      rec.first_text_byte  = b1;
      rec.second_text_byte = b2;
      rec.last_of_run      = 1'b0;
      token_queue.push_back(rec);
      step_count++;
   endfunction

   // keyword number of the open identifier, -1 when it is none
   function automatic int keyword_index_of();
      if (tok_len > PrefixBytes) return -1;
      for (int i = 0; i < KwCount; i++)
         if (KW_LEN[i] == tok_len && KW_TEXT[i] == word_head) return i;
      return -1;
   endfunction

   function automatic void bump_len();
      if (tok_len < TEXT_CAP) tok_len++;
   endfunction

   function automatic void close_open();
      int kw;
      case (lex_mode)
         MODE_IDENT: begin
            kw = keyword_index_of();
            if (kw >= 0) emit(KIND_KEYWORD, kw[3:0], tok_start, tok_len, tok_line, '0, '0);
            else emit(KIND_IDENT, '0, tok_start, tok_len, tok_line, '0, '0);
         end
         MODE_INT:    emit(KIND_INT, '0, tok_start, tok_len, tok_line, '0, '0);
         MODE_STRING: emit(KIND_STRING, '0, tok_start, tok_len, tok_line, '0, '0);
         MODE_PEND:   emit(KIND_OP, '0, tok_start, 8'd1, tok_line, held_op, '0);
         default: ;
      endcase
      lex_mode = MODE_IDLE;
   endfunction

   function automatic void open_token(input logic [7:0] c);
      tok_start = lex_offset;
      tok_line  = lex_line;
      tok_len   = 8'd1;
      word_head = '0;
      held_op   = '0;
      if (c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR}) begin
         lex_mode = MODE_IDLE;
      end else if (is_letter(c)) begin
         lex_mode  = MODE_IDENT;
         word_head = {40'd0, c};
      end else if (is_digit_ch(c)) begin
         lex_mode = MODE_INT;
      end else if (c == CH_QUOTE) begin
         // string text starts after the quote
         lex_mode  = MODE_STRING;
         tok_start = sat_inc(lex_offset);
         tok_len   = '0;
      end else if (c inside {CH_SLASH, CH_EQ, CH_BANG, CH_LT, CH_GT, CH_AMP, CH_BAR}) begin
         lex_mode = MODE_PEND;
         held_op  = c;
      end else if (c inside {CH_PLUS, CH_MINUS, CH_STAR, CH_PCT}) begin
         lex_mode = MODE_IDLE;
         emit(KIND_OP, '0, tok_start, 8'd1, tok_line, c, '0);
      end else begin
         lex_mode = MODE_IDLE;
         emit(KIND_PUNCT, '0, tok_start, 8'd1, tok_line, c, '0);
      end
   endfunction

   function automatic void predict_request(input stt_req_type req);
      logic [7:0]  c;
      stt_rsp_type tail;
      c          = req.in_byte;
      step_count = 0;
      if (req.end_marker || c == CH_NUL) begin
         // end of source: flush the open token, then eof, then back to reset state
         close_open();
         emit(KIND_EOF, '0, lex_offset, '0, lex_line, '0, '0);
         reset_lexer();
      end else begin
         case (lex_mode)
            MODE_IDENT: begin
               if (is_letter(c) || is_digit_ch(c)) begin
                  if (tok_len < PrefixBytes) word_head = {word_head[39:0], c};
                  bump_len();
               end else begin
                  close_open();
                  open_token(c);
               end
            end
            MODE_INT: begin
               if (is_digit_ch(c)) bump_len();
               else begin
                  close_open();
                  open_token(c);
               end
            end
            MODE_STRING: begin
               if (c == CH_QUOTE) close_open();
               else bump_len();
            end
            MODE_COMMENT: begin
               // the closing LF is only a blank
               if (c == CH_LF) lex_mode = MODE_IDLE;
            end
            MODE_PEND: begin
               if (held_op == CH_SLASH && c == CH_SLASH) begin
                  lex_mode = MODE_COMMENT;
               end else if (held_op != CH_SLASH && c == CH_EQ) begin
                  emit(KIND_OP, '0, tok_start, 8'd2, tok_line, held_op, CH_EQ);
                  lex_mode = MODE_IDLE;
               end else begin
                  close_open();
                  open_token(c);
               end
            end
            default: open_token(c);
         endcase
         if (c == CH_LF) lex_line = sat_inc(lex_line);
         lex_offset = sat_inc(lex_offset);
      end
      if (step_count > 0) begin
         tail = token_queue.pop_back();
         tail.last_of_run = 1'b1;
         token_queue.push_back(tail);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers: the initial block fills source_bytes, the driver
   // drains it.
   // ---------------------------------------------------------------------
   byte_slot_type source_bytes[$];
   int            bytes_queued = 0;
   int            tokens_made  = 0;
   bit            drain_next   = 1'b0;
   string         kw_words[KwCount] = '{"fn", "let", "var", "if", "else", "while",
                                        "for", "return", "true", "false", "in"};

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic add_byte(input logic [7:0] b, input logic marker);
      byte_slot_type slot;
      slot.req.in_byte    = b;
      slot.req.end_marker = marker;
      // every fourth block of 128 requests goes without sender gaps
      if (((bytes_queued / 128) % 4) == 1) slot.gap = 0;
      else slot.gap = ($urandom_range(0, 99) < 25) ? pick_gap() : 0;
      slot.drain_first = drain_next || (bytes_queued % 400 == 399)
                         || ($urandom_range(0, 299) == 0);
      drain_next = 1'b0;
      source_bytes.push_back(slot);
      bytes_queued++;
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i], 1'b0);
   endtask

   function automatic logic [7:0] word_char(input bit lead);
      return WORD_CHARS[$urandom_range(0, lead ? 52 : 62)];
   endfunction

   function automatic logic [7:0] string_char();
      logic [7:0] c;
      do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE);
      return c;
   endfunction

   task automatic add_end();
      if ($urandom_range(0, 1)) add_byte(8'($urandom_range(0, 255)), 1'b1);
      else add_byte(CH_NUL, 1'b0);
   endtask

   task automatic add_separator();
      logic [7:0] blanks[4];
      int         n;
      blanks = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};
      n = ($urandom_range(0, 99) < 30) ? 0 : $urandom_range(1, 3);
      repeat (n) add_byte(blanks[$urandom_range(0, 3)], 1'b0);
   endtask

   // one token of saturating length; text_length must stop at 255
   task automatic add_long_token(input int which);
      int n;
      n = $urandom_range(256, 280);
      case (which)
         0: begin
            add_byte(CH_QUOTE, 1'b0);
            repeat (n) add_byte(string_char(), 1'b0);
            add_byte(CH_QUOTE, 1'b0);
         end
         1: begin
            add_byte(word_char(1'b1), 1'b0);
            repeat (n) add_byte(word_char(1'b0), 1'b0);
         end
         default: repeat (n) add_byte(8'($urandom_range(CH_D0, CH_D9)), 1'b0);
      endcase
   endtask

   task automatic add_random_token();
      int    pick, n;
      string w;
      pick = $urandom_range(0, 99);
      tokens_made++;
      if (tokens_made == 40) add_long_token(0);
      else if (tokens_made == 120) add_long_token(1);
      else if (tokens_made == 200) add_long_token(2);
      else if (pick < 15) begin
         // keywords and near misses of them
         w = kw_words[$urandom_range(0, KwCount - 1)];
         case ($urandom_range(0, 3))
            0, 1: add_text(w);
            2: begin
               add_text(w);
               add_byte(word_char(1'b0), 1'b0);
            end
            default: begin
               if ($urandom_range(0, 1)) add_text(w.substr(0, w.len() - 2));
               else begin
                  add_byte(w[0] ^ 8'h20, 1'b0);
                  add_text(w.substr(1, w.len() - 1));
               end
            end
         endcase
      end else if (pick < 30) begin
         n = $urandom_range(0, 8);
         add_byte(word_char(1'b1), 1'b0);
         repeat (n) add_byte(word_char(1'b0), 1'b0);
      end else if (pick < 42) begin
         n = $urandom_range(1, 6);
         repeat (n) add_byte(8'($urandom_range(CH_D0, CH_D9)), 1'b0);
      end else if (pick < 52) begin
         n = $urandom_range(0, 12);
         add_byte(CH_QUOTE, 1'b0);
         repeat (n) add_byte(string_char(), 1'b0);
         add_byte(CH_QUOTE, 1'b0);
      end else if (pick < 68) begin
         add_byte(OP_CHARS[$urandom_range(0, OP_CHARS.len() - 1)], 1'b0);
         if ($urandom_range(0, 1)) add_byte(CH_EQ, 1'b0);
      end else if (pick < 74) begin
         n = $urandom_range(0, 10);
         add_text("//");
         repeat (n) add_byte(($urandom_range(0, 1)) ? string_char() : CH_SLASH, 1'b0);
         add_byte(CH_LF, 1'b0);
      end else if (pick < 82) begin
         if ($urandom_range(0, 2) == 0) add_byte(8'($urandom_range(128, 255)), 1'b0);
         else add_byte(PUNCT_CHARS[$urandom_range(0, PUNCT_CHARS.len() - 1)], 1'b0);
      end else if (pick < 92) begin
         add_byte(8'($urandom_range(1, 255)), 1'b0);
      end else if (pick < 96) begin
         // source cut short inside an open token
         case ($urandom_range(0, 3))
            0: add_byte(CH_SLASH, 1'b0);
            1: add_byte(OP_CHARS[$urandom_range(5, 10)], 1'b0);
            2: begin
               add_byte(CH_QUOTE, 1'b0);
               repeat ($urandom_range(0, 5)) add_byte(string_char(), 1'b0);
            end
            default: add_text("//x");
         endcase
         add_end();
      end else begin
         add_end();
      end
      add_separator();
   endtask

   // ---------------------------------------------------------------------
   // Request driver: payload and valid change only at a rising edge, and
   // only when no request is waiting on the block.
   // ---------------------------------------------------------------------
   int            gap_left = 0;
   byte_slot_type next_slot;

   always @(posedge clock) begin
      if (reset) begin
         req_valid   <= 1'b0;
         req_payload <= '0;
         gap_left     = 0;
      end else begin
         if (req_valid && req_ready) predict_request(req_payload);
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (source_bytes.size() > 0 &&
                         (!source_bytes[0].drain_first || token_queue.size() == 0)) begin
               next_slot    = source_bytes.pop_front();
               gap_left     = next_slot.gap;
               req_valid   <= 1'b1;
               req_payload <= next_slot.req;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Record monitor with random backpressure.
   // ---------------------------------------------------------------------
   int          cycle_count = 0;
   int          stall_left  = 0;
   stt_rsp_type owed;

   function automatic void check_field(input string name, input logic [23:0] want,
                                       input logic [23:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (token_queue.size() == 0) begin
               $error("token record with none owed: kind %0d offset %0h",
                      rsp_payload.token_kind, rsp_payload.start_offset);
               fail_count++;
            end else begin
               owed = token_queue.pop_front();
               check_field("token_kind", 24'(owed.token_kind),
                           24'(rsp_payload.token_kind));
               check_field("keyword_index", 24'(owed.keyword_index),
                           24'(rsp_payload.keyword_index));
               check_field("start_offset", owed.start_offset, rsp_payload.start_offset);
               check_field("text_length", 24'(owed.text_length),
                           24'(rsp_payload.text_length));
               check_field("line_number", owed.line_number, rsp_payload.line_number);
               check_field("first_text_byte", 24'(owed.first_text_byte),
                           24'(rsp_payload.first_text_byte));
               check_field("second_text_byte", 24'(owed.second_text_byte),
                           24'(rsp_payload.second_text_byte));
               check_field("last_of_run", 24'(owed.last_of_run),
                           24'(rsp_payload.last_of_run));
            end
         end
         // the consumer starts no new stall in one stretch in four (cycle_count[11:10] zero)
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (cycle_count[11:10] != 2'd0 && $urandom_range(0, 99) < 20) begin
            stall_left = pick_gap() - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      reset_lexer();

      // keyword, ident, two-byte operator, integer, comment ended by LF, then a
      // string left open at an end marker that carries a stray 0xFF byte
      add_text("while x<=9//c\n\"ab");
      add_byte(8'hFF, 1'b1);
      // non-ASCII punctuation, slash held back then closed by a letter
      add_byte(8'hFF, 1'b0);
      add_byte(8'h80, 1'b0);
      add_text("a/b");
      // pending operator flushed by a NUL byte
      add_byte(CH_BANG, 1'b0);
      add_byte(CH_NUL, 1'b0);

      // random part opens with a full drain
      drain_next = 1'b1;
      while (bytes_queued < ITEM_TARGET) add_random_token();
      add_end();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (source_bytes.size() != 0 || req_valid) @(posedge clock);
      while (token_queue.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule

@@ source_text_tokenizer_unit.f @@
src/stt_pkg.sv
src/source_text_tokenizer_unit.sv
tb/tb_top.sv
